// ===== rtl/usb_plug_debounce_classifier_macros.svh =====
// ---------------------------------------------------------------------------
// USB plug debounce classifier assertion macros
// Concurrent-assertion shorthands for the classifier RTL file.
// ---------------------------------------------------------------------------
`ifndef USB_PLUG_DEBOUNCE_CLASSIFIER_MACROS_SVH
`define USB_PLUG_DEBOUNCE_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled during reset
`define UPDC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("updc assertion failed");

// next-cycle implication, disabled during reset
`define UPDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("updc assertion failed");

`endif

// ===== rtl/updc_pkg.sv =====
// ---------------------------------------------------------------------------
// USB plug debounce classifier package
// Widths, register indexes, event codes and shared types.
// ---------------------------------------------------------------------------
package updc_pkg;

   localparam int unsigned CNT_W       = 8;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 16;

   localparam logic [CNT_W-1:0] CNT_MAX        = 8'hff;
   localparam logic [CNT_W-1:0] DEV_THR_RESET  = 8'd3;
   localparam logic [CNT_W-1:0] HOST_THR_RESET = 8'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DATA_MODE_EN   = 2'd0,
      CSR_DEV_THRESHOLD  = 2'd1,
      CSR_HOST_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DEV_EV_NONE     = 2'd0,
      DEV_EV_CHARGE   = 2'd1,
      DEV_EV_UNCHARGE = 2'd2
   } dev_event_type;

   typedef enum logic [1:0] {
      PAD_NONE    = 2'd0,
      PAD_ENABLE  = 2'd1,
      PAD_RELEASE = 2'd2
   } pad_action_type;

   typedef enum logic [2:0] {
      HOST_EV_NONE        = 3'd0,
      HOST_EV_HOST_IN     = 3'd1,
      HOST_EV_HOST_IN_FAST = 3'd2,
      HOST_EV_HOST_OUT    = 3'd3,
      HOST_EV_DEVICE_IN   = 3'd4,
      HOST_EV_DEVICE_OUT  = 3'd5
   } host_event_type;

   typedef enum logic [1:0] {
      PORT_NONE  = 2'd0,
      PORT_OPEN  = 2'd1,
      PORT_CLOSE = 2'd2
   } host_port_type;

   // debouncer status towards the classifier
   typedef struct packed {
      logic fire;      // level accepted this request
      logic acc_next;  // accepted level after this request
   } deb_status_type;

endpackage

// ===== rtl/usb_plug_debounce_classifier.sv =====
// ---------------------------------------------------------------------------
// USB plug debounce classifier
// Debounces VBUS and the ID-pin host status and reports charge, pad, plug
// and host-port events, one response per request.
// ---------------------------------------------------------------------------
// Channel   Ports                      Contents
// req       req_tvalid/tready/tdata    sampled VBUS and ID pins
// rsp       rsp_tvalid/tready/tdata    device, pad, host and port events
// csr       csr_we/index/wdata         mode and debounce thresholds
//
// Input register, then the debounce and classify logic into the response
// register. One request per cycle sustained while responses are taken.
// A request is taken while a response waits, until the input register fills.
// Synchronous reset clears the debouncers, the latches and the thresholds
// back to mode on, 3 and 10. No clearing pass.
// ---------------------------------------------------------------------------
module usb_plug_debounce_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] vbus_present, [1] id_pin_a, [2] id_pin_b, [7:3] zero
   input  logic [updc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] dev_event, [3:2] pad_action, [6:4] host_event, [8:7] host_port,
   // [15:9] zero
   output logic [updc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [updc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [updc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import updc_pkg::*;
   `include "usb_plug_debounce_classifier_macros.svh"

   // configuration
   logic             data_mode_ff;
   logic [CNT_W-1:0] dev_thr_ff;
   logic [CNT_W-1:0] host_thr_ff;

   // input register
   logic in_valid_ff, in_valid_in;
   logic vbus_ff, pin_a_ff, pin_b_ff;

   // classifier state
   logic first_valid_ff, first_valid_in;
   logic first_level_ff, first_level_in;
   logic is_device_ff, is_device_in;

   // response register
   logic           out_valid_ff, out_valid_in;
   dev_event_type  dev_ev_ff, dev_ev_in;
   pad_action_type pad_ff, pad_in;
   host_event_type host_ev_ff, host_ev_in;
   host_port_type  port_ff, port_in;

   logic           advance, step, host_status, first_level_use;
   deb_status_type dev_st, host_st;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   assign host_status = pin_a_ff ^ pin_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_mode_ff <= 1'b1;
         dev_thr_ff   <= DEV_THR_RESET;
         host_thr_ff  <= HOST_THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DATA_MODE_EN:   data_mode_ff <= csr_wdata[0];
            CSR_DEV_THRESHOLD:  dev_thr_ff   <= csr_wdata[CNT_W-1:0];
            CSR_HOST_THRESHOLD: host_thr_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         vbus_ff  <= req_tdata[0];
         pin_a_ff <= req_tdata[1];
         pin_b_ff <= req_tdata[2];
      end
   end

   updc_debouncer u_dev_deb (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .level     (vbus_ff),
      .threshold (dev_thr_ff),
      .status    (dev_st)
   );

   updc_debouncer u_host_deb (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .level     (host_status),
      .threshold (host_thr_ff),
      .status    (host_st)
   );

   // first-scan level, latched on the first request after reset
   assign first_level_use = first_valid_ff ? first_level_ff : host_status;

   always_comb begin
      first_valid_in = first_valid_ff;
      first_level_in = first_level_ff;
      is_device_in   = is_device_ff;
      out_valid_in   = out_valid_ff;
      dev_ev_in      = dev_ev_ff;
      pad_in         = pad_ff;
      host_ev_in     = host_ev_ff;
      port_in        = port_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
      if (step) begin
         first_valid_in = 1'b1;
         first_level_in = first_level_use;
         dev_ev_in  = DEV_EV_NONE;
         pad_in     = PAD_NONE;
         host_ev_in = HOST_EV_NONE;
         port_in    = PORT_NONE;
         if (dev_st.fire) begin
            dev_ev_in = vbus_ff ? DEV_EV_CHARGE : DEV_EV_UNCHARGE;
            if (data_mode_ff) begin
               pad_in = vbus_ff ? PAD_ENABLE : PAD_RELEASE;
            end
         end
         if (host_st.fire) begin
            if (host_status) begin
               if (data_mode_ff && dev_st.acc_next) begin
                  is_device_in = 1'b1;
                  host_ev_in   = HOST_EV_DEVICE_IN;
               end else begin
                  is_device_in = 1'b0;
                  port_in      = PORT_OPEN;
                  host_ev_in   = (data_mode_ff && !first_level_use) ?
                                 HOST_EV_HOST_IN_FAST : HOST_EV_HOST_IN;
               end
            end else if (data_mode_ff && is_device_ff) begin
               host_ev_in = HOST_EV_DEVICE_OUT;
            end else begin
               port_in    = PORT_CLOSE;
               host_ev_in = HOST_EV_HOST_OUT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         first_valid_ff <= 1'b0;
         first_level_ff <= 1'b0;
         is_device_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         first_valid_ff <= first_valid_in;
         first_level_ff <= first_level_in;
         is_device_ff   <= is_device_in;
      end
   end

   always_ff @(posedge clock) begin
      dev_ev_ff  <= dev_ev_in;
      pad_ff     <= pad_in;
      host_ev_ff <= host_ev_in;
      port_ff    <= port_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, port_ff, host_ev_ff, pad_ff, dev_ev_ff};

   `UPDC_ASSERT_IMPLIES(a_open_is_host_in, clock, reset,
      out_valid_ff && port_ff == PORT_OPEN,
      host_ev_ff == HOST_EV_HOST_IN || host_ev_ff == HOST_EV_HOST_IN_FAST)
   `UPDC_ASSERT_IMPLIES(a_pad_needs_dev_ev, clock, reset,
      out_valid_ff && pad_ff != PAD_NONE, dev_ev_ff != DEV_EV_NONE)
   `UPDC_ASSERT_NEXT(a_first_latched, clock, reset, step, first_valid_ff)
   `UPDC_ASSERT_IMPLIES(a_stall_only_when_full, clock, reset,
      !req_tready, in_valid_ff && out_valid_ff)

endmodule

// ===== rtl/updc_debouncer.sv =====
// ---------------------------------------------------------------------------
// Level debouncer
// Held level, accepted level and saturating repeat count; accepts a level
// once it has repeated for the threshold count.
// ---------------------------------------------------------------------------
module updc_debouncer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          level,
   input  logic [updc_pkg::CNT_W-1:0]    threshold,
   output updc_pkg::deb_status_type      status
);
   import updc_pkg::*;

   logic             held_ff, held_in;
   logic             acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_inc;
   logic             fire;

   assign cnt_inc = (cnt_ff == CNT_MAX) ? CNT_MAX : cnt_ff + 1'b1;

   always_comb begin
      held_in = held_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      fire    = 1'b0;
      if (step) begin
         if (level != held_ff) begin
            held_in = level;
            cnt_in  = '0;
         end else if (level != acc_ff) begin
            cnt_in = cnt_inc;
            if (cnt_inc >= threshold) begin
               acc_in = level;
               fire   = 1'b1;
            end
         end
      end
   end

   assign status.fire     = fire;
   assign status.acc_next = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         acc_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         held_ff <= held_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
